// File: src/cna_pkg.sv
// shared types, constants and helpers for the complex-number alu
package cna_pkg;

  localparam int FRAC_BITS = 8;
  // working width of the divider remainder: holds divisor << 16 plus headroom
  localparam int REM_W = 49;
  localparam int QBITS = 17;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_EQ,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               saturated;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } work_t;

  typedef struct packed {
    logic signed [15:0] v;
    logic               clip;
  } sat_t;

  function automatic sat_t sat16(input logic signed [33:0] x);
    sat_t r;
    if (x > 34'sd32767) begin
      r.v = 16'sh7fff;
      r.clip = 1'b1;
    end else if (x < -34'sd32768) begin
      r.v = 16'sh8000;
      r.clip = 1'b1;
    end else begin
      r.v = x[15:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: src/complex_number_alu.sv
// top level of the complex-number alu: front, queue and back
//
//   channel | direction | payload    | handshake
//   in_     | input     | in_item_t  | in_valid / in_ready
//   out_    | output    | out_item_t | out_valid / out_ready
//
// one item per cycle sustained while out_ready keeps results moving; each result passes the front
// register, a queue slot, the product and combine stages, the 17-stage restoring divider and the
// output register.
// the divider pipeline and the output register advance together and hold
// when a result waits; the queue keeps the front taking beats meanwhile, until it fills.
// synchronous active-low reset clears all valid bits and queue pointers.
module complex_number_alu import cna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic  f_valid;
  logic  f_ready;
  work_t f_data;
  logic  w_valid;
  logic  w_ready;
  work_t w_data;

  cna_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  cna_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (w_valid),
    .pop_ready  (w_ready),
    .pop_data   (w_data)
  );

  cna_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_valid   (w_valid),
    .w_ready   (w_ready),
    .w_data    (w_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.saturated)
    else $error("divide by zero result not cleared");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_equal && (out_data.div_zero || out_data.saturated)))
    else $error("conflicting result flags");

  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_equal |-> out_data.res_re == '0 && out_data.res_im == '0)
    else $error("compare result not zero");

endmodule

// File: src/cna_front.sv
// front end: takes input beats and classifies the opcode
module cna_front import cna_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     f_valid,
  input  logic     f_ready,
  output work_t    f_data
);

  logic  f_valid_r;
  work_t f_r;
  work_t f_nxt;

  assign in_ready = !f_valid_r || f_ready;
  assign f_valid  = f_valid_r;
  assign f_data   = f_r;

  always_comb begin
    f_nxt.a_re = in_data.a_re;
    f_nxt.a_im = in_data.a_im;
    f_nxt.b_re = in_data.b_re;
    f_nxt.b_im = in_data.b_im;
    case (in_data.opcode)
      OP_ADD:  f_nxt.kind = K_ADD;
      OP_SUB:  f_nxt.kind = K_SUB;
      OP_MUL:  f_nxt.kind = K_MUL;
      OP_DIV:  f_nxt.kind = K_DIV;
      OP_EQ:   f_nxt.kind = K_EQ;
      default: f_nxt.kind = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      f_r <= f_nxt;
    end
  end

endmodule

// File: src/cna_queue.sv
// four-entry queue between front and back
module cna_queue import cna_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  work_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != (AW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// File: src/cna_back.sv
// back end: product stage, combine stage, pipelined divider, output register
module cna_back import cna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      w_valid,
  output logic      w_ready,
  input  work_t     w_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int NSTG = QBITS;

  typedef struct packed {
    kind_t              kind;
    out_item_t          res;
    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_ir;
    logic signed [31:0] p_bb1;
    logic signed [31:0] p_bb2;
  } prod_t;

  typedef struct packed {
    logic             div;
    out_item_t        res;
    logic [31:0]      dvs;
    logic [REM_W-1:0] rem_re;
    logic [REM_W-1:0] rem_im;
    logic [QBITS-1:0] q_re;
    logic [QBITS-1:0] q_im;
    logic             neg_re;
    logic             neg_im;
  } dv_t;

  logic      en;
  logic      s0_valid_r;
  prod_t     s0_r;
  prod_t     s0_nxt;
  logic      dv_valid_r [NSTG+1];
  dv_t       dv_r [NSTG+1];
  dv_t       dv_nxt;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t out_nxt;

  assign en        = !out_valid_r || out_ready;
  assign w_ready   = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // products, and the operations that need none
  always_comb begin
    sat_t s_re;
    sat_t s_im;
    s_re = sat16(34'(w_data.a_re) + 34'(w_data.b_re));
    s_im = sat16(34'(w_data.a_im) + 34'(w_data.b_im));
    s0_nxt.kind  = w_data.kind;
    s0_nxt.p_rr  = w_data.a_re * w_data.b_re;
    s0_nxt.p_ii  = w_data.a_im * w_data.b_im;
    s0_nxt.p_ri  = w_data.a_re * w_data.b_im;
    s0_nxt.p_ir  = w_data.a_im * w_data.b_re;
    s0_nxt.p_bb1 = w_data.b_re * w_data.b_re;
    s0_nxt.p_bb2 = w_data.b_im * w_data.b_im;
    s0_nxt.res   = '0;
    case (w_data.kind)
      K_ADD: begin
        s0_nxt.res.res_re    = s_re.v;
        s0_nxt.res.res_im    = s_im.v;
        s0_nxt.res.saturated = s_re.clip || s_im.clip;
      end
      K_SUB: begin
        s_re = sat16(34'(w_data.a_re) - 34'(w_data.b_re));
        s_im = sat16(34'(w_data.a_im) - 34'(w_data.b_im));
        s0_nxt.res.res_re    = s_re.v;
        s0_nxt.res.res_im    = s_im.v;
        s0_nxt.res.saturated = s_re.clip || s_im.clip;
      end
      K_EQ: begin
        s0_nxt.res.is_equal = (w_data.a_re == w_data.b_re) && (w_data.a_im == w_data.b_im);
      end
      default: begin
      end
    endcase
  end

  // sums of products; multiply finishes here, divide sets up its operands
  always_comb begin
    logic signed [33:0] m_re;
    logic signed [33:0] m_im;
    logic signed [33:0] n_re;
    logic signed [33:0] n_im;
    logic [33:0]        mag_re;
    logic [33:0]        mag_im;
    sat_t s_re;
    sat_t s_im;
    m_re = 34'(s0_r.p_rr) - 34'(s0_r.p_ii);
    m_im = 34'(s0_r.p_ri) + 34'(s0_r.p_ir);
    n_re = 34'(s0_r.p_rr) + 34'(s0_r.p_ii);
    n_im = 34'(s0_r.p_ir) - 34'(s0_r.p_ri);
    mag_re = n_re[33] ? 34'(-n_re) : 34'(n_re);
    mag_im = n_im[33] ? 34'(-n_im) : 34'(n_im);
    s_re = sat16(m_re >>> FRAC_BITS);
    s_im = sat16(m_im >>> FRAC_BITS);
    dv_nxt.res    = s0_r.res;
    dv_nxt.dvs    = 32'($unsigned(s0_r.p_bb1)) + 32'($unsigned(s0_r.p_bb2));
    dv_nxt.rem_re = REM_W'(mag_re[31:0]) << FRAC_BITS;
    dv_nxt.rem_im = REM_W'(mag_im[31:0]) << FRAC_BITS;
    dv_nxt.q_re   = '0;
    dv_nxt.q_im   = '0;
    dv_nxt.neg_re = n_re[33];
    dv_nxt.neg_im = n_im[33];
    dv_nxt.div    = 1'b0;
    case (s0_r.kind)
      K_MUL: begin
        dv_nxt.res.res_re    = s_re.v;
        dv_nxt.res.res_im    = s_im.v;
        dv_nxt.res.saturated = s_re.clip || s_im.clip;
      end
      K_DIV: begin
        dv_nxt.div          = (dv_nxt.dvs != '0);
        dv_nxt.res.div_zero = (dv_nxt.dvs == '0);
      end
      default: begin
      end
    endcase
  end

  // one quotient bit per stage, most significant first; the top bit flags overflow
  for (genvar j = 0; j < NSTG; j++) begin : g_div
    localparam int B = NSTG - 1 - j;
    dv_t              st;
    logic [REM_W-1:0] dsh_w;
    always_comb begin
      st    = dv_r[j];
      dsh_w = REM_W'(dv_r[j].dvs) << B;
      if (dv_r[j].rem_re >= dsh_w) begin
        st.rem_re  = dv_r[j].rem_re - dsh_w;
        st.q_re[B] = 1'b1;
      end
      if (dv_r[j].rem_im >= dsh_w) begin
        st.rem_im  = dv_r[j].rem_im - dsh_w;
        st.q_im[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid_r[j+1] <= dv_valid_r[j];
      end
      if (en) dv_r[j+1] <= st;
    end
  end

  function automatic sat_t fin(input logic [QBITS-1:0] q, input logic neg);
    sat_t r;
    if (neg) begin
      if (q[16] || (q[15] && (q[14:0] != '0))) begin
        r.v = 16'sh8000;
        r.clip = 1'b1;
      end else begin
        r.v = -q[15:0];
        r.clip = 1'b0;
      end
    end else begin
      if (q[16] || q[15]) begin
        r.v = 16'sh7fff;
        r.clip = 1'b1;
      end else begin
        r.v = q[15:0];
        r.clip = 1'b0;
      end
    end
    return r;
  endfunction

  always_comb begin
    sat_t f_re;
    sat_t f_im;
    f_re    = fin(dv_r[NSTG].q_re, dv_r[NSTG].neg_re);
    f_im    = fin(dv_r[NSTG].q_im, dv_r[NSTG].neg_im);
    out_nxt = dv_r[NSTG].res;
    if (dv_r[NSTG].div) begin
      out_nxt.res_re    = f_re.v;
      out_nxt.res_im    = f_im.v;
      out_nxt.saturated = f_re.clip || f_im.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      dv_valid_r[0] <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      s0_valid_r    <= w_valid;
      dv_valid_r[0] <= s0_valid_r;
      out_valid_r   <= dv_valid_r[NSTG];
    end
    if (en) begin
      s0_r     <= s0_nxt;
      dv_r[0]  <= dv_nxt;
      out_r    <= out_nxt;
    end
  end

endmodule

// File: test/tb.sv
// self-checking testbench for the complex-number alu
`timescale 1ns / 1ps
module tb;
  import cna_pkg::*;

  localparam int QSCALE = 1 << FRAC_BITS;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  out_item_t alu_results_q[$];
  int        mismatches;
  int        idle_cycles;
  bit        stall_enable;
  int        stall_mode = 1;

  complex_number_alu u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clip16(input longint v, inout bit clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint floor_div(input longint v);
    if (v >= 0) return v / QSCALE;
    return -((-v + QSCALE - 1) / QSCALE);
  endfunction

  // expected result of one operand pair
  function automatic out_item_t alu_compute(input in_item_t it);
    out_item_t r;
    longint ar, ai, br, bi, rr, ri, d;
    bit clip;
    ar = it.a_re;
    ai = it.a_im;
    br = it.b_re;
    bi = it.b_im;
    rr = 0;
    ri = 0;
    clip = 1'b0;
    r = '0;
    case (it.opcode)
      OP_ADD: begin
        rr = clip16(ar + br, clip);
        ri = clip16(ai + bi, clip);
      end
      OP_SUB: begin
        rr = clip16(ar - br, clip);
        ri = clip16(ai - bi, clip);
      end
      OP_MUL: begin
        rr = clip16(floor_div(ar * br - ai * bi), clip);
        ri = clip16(floor_div(ar * bi + ai * br), clip);
      end
      OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.div_zero = 1'b1;
        end else begin
          // longint division truncates toward zero
          rr = clip16((ar * br + ai * bi) * QSCALE / d, clip);
          ri = clip16((ai * br - ar * bi) * QSCALE / d, clip);
        end
      end
      OP_EQ: r.is_equal = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.res_re = rr[15:0];
    r.res_im = ri[15:0];
    r.saturated = clip;
    return r;
  endfunction

  // valid stays up after the beat; the caller drops it before a gap
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    alu_results_q.push_back(alu_compute(it));
  endtask

  // bursts with random gaps between them
  task automatic send_burst(input in_item_t items[$]);
    int burst;
    burst = 0;
    foreach (items[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      send_item(items[i]);
      burst--;
    end
  endtask

  function automatic in_item_t rand_item(input bit well_formed);
    in_item_t it;
    int sel;
    it.opcode = well_formed ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
    it.a_re = 16'($urandom);
    it.a_im = 16'($urandom);
    it.b_re = 16'($urandom);
    it.b_im = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      // small magnitudes keep mul out of saturation
      it.a_re = 16'($signed(12'($urandom)));
      it.a_im = 16'($signed(12'($urandom)));
      it.b_re = 16'($signed(12'($urandom)));
      it.b_im = 16'($signed(12'($urandom)));
    end else if (sel == 3) begin
      it.b_re = it.a_re;
      it.b_im = $urandom_range(0, 1) ? it.a_im : 16'($urandom);
    end else if (sel == 4) begin
      it.b_re = '0;
      it.b_im = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic test_directed();
    in_item_t items[$];
    in_item_t it;
    logic signed [15:0] ext[4];
    ext = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1};
    for (int op = 0; op < 8; op++) begin
      it.opcode = 3'(op);
      it.a_re = ext[op % 4];
      it.a_im = ext[(op + 1) % 4];
      it.b_re = ext[(op + 2) % 4];
      it.b_im = ext[(op + 3) % 4];
      items.push_back(it);
    end
    // divide by zero, equal compare, full-scale mul and div, saturating add and sub
    items.push_back('{OP_DIV, 16'sh0100, 16'sh0200, 16'sd0, 16'sd0});
    items.push_back('{OP_DIV, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0});
    items.push_back('{OP_EQ, 16'sh1234, -16'sd5, 16'sh1234, -16'sd5});
    items.push_back('{OP_EQ, 16'sh1234, -16'sd5, 16'sh1234, -16'sd4});
    items.push_back('{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    items.push_back('{OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
    items.push_back('{OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0});
    items.push_back('{OP_DIV, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd0});
    items.push_back('{OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000});
    items.push_back('{OP_DIV, -16'sd1, 16'sd1, 16'sh0300, 16'sd7});
    items.push_back('{OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    items.push_back('{OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    send_burst(items);
  endtask

  task automatic test_random(input int count);
    in_item_t items[$];
    for (int i = 0; i < count; i++)
      items.push_back(rand_item($urandom_range(0, 9) != 0));
    send_burst(items);
  endtask

  task automatic test_full_rate(input int count);
    stall_enable = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_item(rand_item(1'b1));
    end
    stall_enable = 1'b1;
  endtask

  // receiver stalls on its own pattern
  always @(posedge clk) begin
    if (!rst_n || !stall_enable) begin
      out_ready <= 1'b1;
    end else begin
      stall_mode <= ($urandom_range(0, 63) == 0) ? int'($urandom_range(0, 3)) : stall_mode;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 3) != 0;
        2: out_ready <= $urandom_range(0, 1) != 0;
        default: out_ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (alu_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_data);
      end else begin
        exp_r = alu_results_q.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stall_enable = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_full_rate(100);
    test_random(100);
    in_valid <= 1'b0;
    while (alu_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && alu_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: complex_number_alu.f
src/cna_pkg.sv
src/cna_front.sv
src/cna_queue.sv
src/cna_back.sv
src/complex_number_alu.sv
test/tb.sv
